>>> rtl/core/servo_reply_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Servo reply frame receiver assertion macros
// Shared concurrent assertion forms used by the receiver checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_FRAME_RECEIVER_MACROS_SVH
`define SERVO_REPLY_FRAME_RECEIVER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRFR_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("srfr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SRFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("srfr assertion failed");

`endif

>>> rtl/core/srfr_pkg.sv
// ----------------------------------------------------------------------------
// Servo reply frame receiver package
// Types, constants and result field positions shared by the receiver files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srfr_pkg;

	// Default frame buffer size in bytes.
	localparam int FRAME_BYTES_DEF = 20;

	// Header byte value and frame overhead (two headers, ID, length).
	localparam logic [7:0] HDR_BYTE       = 8'hFF;
	localparam int         FRAME_OVERHEAD = 4;

	// Receive phases.
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HDR2 = 3'd1,
		PH_ID   = 3'd2,
		PH_LEN  = 3'd3,
		PH_BODY = 3'd4
	} srfr_phase_t;

	// Control state carried between items (write position travels apart,
	// since its width follows the buffer size).
	typedef struct packed {
		srfr_phase_t phase;
		logic [7:0]  frame_len;
		logic        held;
	} srfr_ctl_t;

	// One result item.
	typedef struct packed {
		logic       byte_stored;
		logic [4:0] store_index;
		logic [7:0] store_value;
		logic       frame_done;
		logic [7:0] declared_len;
		logic       overflow_drop;
		logic       held;
	} srfr_result_t;

	// Result item layout on the output data bus, lowest bit first.
	localparam int OUT_STORED_BIT = 0;
	localparam int OUT_INDEX_LSB  = 1;
	localparam int OUT_VALUE_LSB  = 6;
	localparam int OUT_DONE_BIT   = 14;
	localparam int OUT_LEN_LSB    = 15;
	localparam int OUT_OVF_BIT    = 23;
	localparam int OUT_HELD_BIT   = 24;
	localparam int OUT_TDATA_W    = 32;

endpackage

>>> rtl/core/srfr_step.sv
// ----------------------------------------------------------------------------
// Servo reply frame receiver step
// Next-state and result logic for one received byte or release item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srfr_step #(
	parameter int FRAME_BYTES = srfr_pkg::FRAME_BYTES_DEF,
	parameter int POS_W       = $clog2(FRAME_BYTES + 1)
) (
	input  logic                 action,
	input  logic [7:0]           rx_byte,
	input  srfr_pkg::srfr_ctl_t  ctl,
	input  logic [POS_W-1:0]     pos,
	output srfr_pkg::srfr_ctl_t  ctl_nxt,
	output logic [POS_W-1:0]     pos_nxt,
	output srfr_pkg::srfr_result_t result
);
	import srfr_pkg::*;

	// Compare width covers both the length sum and the advanced position.
	localparam int CW = ((POS_W > 8) ? POS_W : 8) + 1;
	// Index width before trimming to the five-bit result field.
	localparam int IW = (POS_W > 5) ? POS_W : 5;

	logic [POS_W-1:0] pos_inc;
	logic [CW-1:0]    new_len_end;
	logic [CW-1:0]    cur_len_end;
	logic [IW-1:0]    pos_x;

	assign pos_inc     = pos + POS_W'(1);
	assign new_len_end = CW'(rx_byte) + CW'(FRAME_OVERHEAD);
	assign cur_len_end = CW'(ctl.frame_len) + CW'(FRAME_OVERHEAD);
	assign pos_x       = IW'(pos);

	// One state step per item.
	always_comb begin
		ctl_nxt = ctl;
		pos_nxt = pos;
		result  = '0;
		if (action) begin
			ctl_nxt.held = 1'b0;
		end else if (!ctl.held) begin
			case (ctl.phase)
				PH_HDR2: begin
					result.byte_stored = 1'b1;
					result.store_index = pos_x[4:0];
					result.store_value = rx_byte;
					pos_nxt            = pos_inc;
					ctl_nxt.phase      = (rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT;
				end
				PH_ID: begin
					result.byte_stored = 1'b1;
					result.store_index = pos_x[4:0];
					result.store_value = rx_byte;
					pos_nxt            = pos_inc;
					ctl_nxt.phase      = PH_LEN;
				end
				PH_LEN: begin
					ctl_nxt.frame_len = rx_byte;
					if (new_len_end > CW'(FRAME_BYTES)) begin
						// Declared frame would overrun the buffer: drop it.
						result.overflow_drop = 1'b1;
						ctl_nxt.phase        = PH_HUNT;
						pos_nxt              = '0;
					end else begin
						result.byte_stored = 1'b1;
						result.store_index = pos_x[4:0];
						result.store_value = rx_byte;
						pos_nxt            = pos_inc;
						if (CW'(pos_inc) == new_len_end) begin
							result.frame_done = 1'b1;
							ctl_nxt.held      = 1'b1;
							ctl_nxt.phase     = PH_HUNT;
						end else begin
							ctl_nxt.phase = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					result.byte_stored = 1'b1;
					result.store_index = pos_x[4:0];
					result.store_value = rx_byte;
					pos_nxt            = pos_inc;
					if (CW'(pos_inc) >= cur_len_end) begin
						result.frame_done = 1'b1;
						ctl_nxt.held      = 1'b1;
						ctl_nxt.phase     = PH_HUNT;
					end
				end
				default: begin
					// Hunting for the first header byte.
					result.byte_stored = 1'b1;
					result.store_value = rx_byte;
					pos_nxt            = POS_W'(1);
					ctl_nxt.phase      = (rx_byte == HDR_BYTE) ? PH_HDR2 : PH_HUNT;
				end
			endcase
		end
		result.declared_len = ctl_nxt.frame_len;
		result.held         = ctl_nxt.held;
	end

endmodule

>>> rtl/core/servo_reply_frame_receiver.sv
// ----------------------------------------------------------------------------
// Servo reply frame receiver
// Hunts for reply frames in a received byte stream and reports each byte
// with its frame buffer position.
// ----------------------------------------------------------------------------
// The block takes one item per clock: a received byte, or a release of the
// held frame. Each item yields exactly one result item, which sits in the
// output register from the cycle after acceptance. The input is ready
// whenever that register is empty or is being taken in the same cycle, so a
// steady stream moves at one item per clock; the rate is set by the single
// receive state step between the state registers and the output register.
// A completed frame holds the receiver: later bytes are reported as not
// stored until a release item arrives. There is no start-up clearing pass.
`timescale 1ns / 1ps

module servo_reply_frame_receiver #(
	parameter int FRAME_BYTES = srfr_pkg::FRAME_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
	input  logic                               s_tuser,   // [0] action
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] byte_stored, [5:1] store_index, [13:6] store_value, [14] frame_done,
	// [22:15] declared_len, [23] overflow_drop, [24] held, [31:25] zero
	output logic [srfr_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import srfr_pkg::*;

	localparam int POS_W = $clog2(FRAME_BYTES + 1);

	srfr_ctl_t        ctl_q;
	srfr_ctl_t        ctl_nxt;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_nxt;
	srfr_result_t     result;
	srfr_result_t     result_q;
	logic             m_valid_q;
	logic             in_take;

	// Input is taken while the output register is free or draining.
	assign s_tready = !m_valid_q || m_tready;
	assign in_take  = s_tvalid && s_tready;

	srfr_step #(
		.FRAME_BYTES(FRAME_BYTES),
		.POS_W      (POS_W)
	) u_step (
		.action (s_tuser),
		.rx_byte(s_tdata),
		.ctl    (ctl_q),
		.pos    (pos_q),
		.ctl_nxt(ctl_nxt),
		.pos_nxt(pos_nxt),
		.result (result)
	);

	// Receive state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{phase: PH_HUNT, frame_len: 8'd0, held: 1'b0};
			pos_q <= '0;
		end else if (in_take) begin
			ctl_q <= ctl_nxt;
			pos_q <= pos_nxt;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (in_take) begin
			result_q <= result;
		end
	end

	// Pack the result item onto the output bus.
	always_comb begin
		m_tdata                                   = '0;
		m_tdata[OUT_STORED_BIT]                   = result_q.byte_stored;
		m_tdata[OUT_INDEX_LSB +: 5]               = result_q.store_index;
		m_tdata[OUT_VALUE_LSB +: 8]               = result_q.store_value;
		m_tdata[OUT_DONE_BIT]                     = result_q.frame_done;
		m_tdata[OUT_LEN_LSB +: 8]                 = result_q.declared_len;
		m_tdata[OUT_OVF_BIT]                      = result_q.overflow_drop;
		m_tdata[OUT_HELD_BIT]                     = result_q.held;
	end

	assign m_tvalid = m_valid_q;

endmodule

>>> rtl/core/srfr_checker.sv
// ----------------------------------------------------------------------------
// Servo reply frame receiver checker
// Port-level assertions on the receiver, attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_reply_frame_receiver_macros.svh"

module srfr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [srfr_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import srfr_pkg::*;

	// Result flags picked off the output bus.
	logic out_stored;
	logic out_done;
	logic out_ovf;
	logic out_held;

	assign out_stored = m_tdata[OUT_STORED_BIT];
	assign out_done   = m_tdata[OUT_DONE_BIT];
	assign out_ovf    = m_tdata[OUT_OVF_BIT];
	assign out_held   = m_tdata[OUT_HELD_BIT];

	// A stalled result item holds its value.
	`SRFR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Every accepted item shows up as a result item in the next cycle.
	`SRFR_ASSERT_NEXT(a_in_to_out, clk, arst_n, s_tvalid && s_tready, m_tvalid)

	// A completed frame is reported as held.
	`SRFR_ASSERT_SAME(a_done_held, clk, arst_n, m_tvalid && out_done, out_held)

	// A dropped frame never stores its length byte.
	`SRFR_ASSERT_SAME(a_ovf_nostore, clk, arst_n, m_tvalid && out_ovf, !out_stored && !out_done)

endmodule

bind servo_reply_frame_receiver srfr_checker u_srfr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
